### rtl/core/ipr_pkg.sv
// ipr_pkg: field widths and action codes for the ip range table lookup
// no dependencies; used by the channel interfaces, the top level and its checker
package ipr_pkg;

    localparam int ACT_W   = 1;
    localparam int SLOT_W  = 8;
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 9;

    localparam logic [ACT_W-1:0] ACT_LOAD   = 1'b0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 1'b1;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

### rtl/core/ipr_if.sv
// ipr_req_if / ipr_rsp_if: valid/ready channels for request and response words
// depends on ipr_pkg
interface ipr_req_if import ipr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    t_slot            entry_slot;
    t_addr            range_first;
    t_addr            range_last;
    t_addr            address;

    modport source (output valid, action, entry_slot, range_first, range_last, address,
                    input ready);
    modport sink (input valid, action, entry_slot, range_first, range_last, address,
                  output ready);
endinterface

interface ipr_rsp_if import ipr_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  hit;
    t_slot match_slot;

    modport source (output valid, hit, match_slot, input ready);
    modport sink (input valid, hit, match_slot, output ready);
endinterface

### rtl/core/ip_range_table_lookup.sv
// ip_range_table_lookup: range table in two synchronous memories with a binary search
// depends on ipr_pkg and the channel interfaces in ipr_if.sv
//
// A load word writes one range entry and gives no response. A lookup word is taken while
// the block is idle, then probes the table once per cycle, the final probe holding until
// the output register is free: each probe reads first[mid], last[mid] and first[mid+1]
// from the memories and picks the next mid from the registered read data. With n =
// min(entry_count, TABLE_DEPTH) a lookup needs at most floor(log2(n)) + 1 probes, 9 for a
// full table of 256, and the request side is not ready until the response is registered;
// an empty table answers a miss without probing. The response sits in an output register,
// so a new word is taken while the previous response waits. No clearing pass is run after
// reset: entries hold whatever was last loaded, and the search only uses entries below n.
module ip_range_table_lookup import ipr_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  t_count       i_cfg_data,
    ipr_req_if.sink      i_req,
    ipr_rsp_if.source    o_rsp
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EMPTY  = 2'd2;

    logic [1:0]    r_state, n_state;
    t_count        r_entry_count;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hip1, n_hip1;
    logic [IW-1:0] r_mid, n_mid;
    t_addr         r_addr, n_addr;

    t_addr r_first_mem [TABLE_DEPTH];
    t_addr r_last_mem  [TABLE_DEPTH];
    t_addr r_rd_first, r_rd_last, r_rd_next;

    logic          r_out_valid;
    logic          r_out_hit;
    t_slot         r_out_slot;

    logic          w_req_acc;
    logic          w_load;
    logic [CW-1:0] w_n;
    logic [IW-1:0] w_mid0;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_rd_next_addr;
    logic          w_out_free;
    logic          w_fin;
    logic          w_fin_hit;
    logic [CW-1:0] w_mid_c;
    logic          w_lt, w_in, w_at_hi, w_gap;
    logic [CW:0]   w_sum_l, w_sum_r;
    logic [IW-1:0] w_mid_l, w_mid_r;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_load      = w_req_acc && (i_req.action == ACT_LOAD)
                         && (32'(i_req.entry_slot) < TABLE_DEPTH);

    // searched count saturates at the table depth
    assign w_n    = (32'(r_entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                       : CW'(r_entry_count);
    assign w_mid0 = IW'((w_n - CW'(1)) >> 1);

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // probe evaluation on registered read data
    assign w_mid_c = CW'(r_mid);
    assign w_lt    = r_addr < r_rd_first;
    assign w_in    = r_addr <= r_rd_last;
    assign w_at_hi = (CW'(w_mid_c + CW'(1)) == r_hip1);
    assign w_gap   = w_at_hi || (r_addr < r_rd_next);
    assign w_sum_l = {1'b0, r_lo} + {1'b0, w_mid_c} - (CW+1)'(1);
    assign w_sum_r = {1'b0, w_mid_c} + {1'b0, r_hip1};
    assign w_mid_l = IW'(w_sum_l >> 1);
    assign w_mid_r = IW'(w_sum_r >> 1);

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hip1    = r_hip1;
        n_mid     = r_mid;
        n_addr    = r_addr;
        w_rd_addr = r_mid;
        w_fin     = 1'b0;
        w_fin_hit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc && (i_req.action == ACT_LOOKUP)) begin
                    n_addr = i_req.address;
                    if (w_n == '0) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_lo      = '0;
                        n_hip1    = w_n;
                        n_mid     = w_mid0;
                        w_rd_addr = w_mid0;
                        n_state   = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_lt) begin
                    if (r_lo >= w_mid_c) begin
                        w_fin = 1'b1;
                    end else begin
                        n_hip1    = w_mid_c;
                        n_mid     = w_mid_l;
                        w_rd_addr = w_mid_l;
                    end
                end else if (w_in) begin
                    w_fin     = 1'b1;
                    w_fin_hit = 1'b1;
                end else if (w_gap) begin
                    w_fin = 1'b1;
                end else begin
                    n_lo      = CW'(w_mid_c + CW'(1));
                    n_mid     = w_mid_r;
                    w_rd_addr = w_mid_r;
                end
                // hold the probe (and its read data) until the output register frees
                if (w_fin && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                w_fin = 1'b1;
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_rd_next_addr = IW'(w_rd_addr + IW'(1));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_first_mem[IW'(i_req.entry_slot)] <= i_req.range_first;
            r_last_mem[IW'(i_req.entry_slot)]  <= i_req.range_last;
        end
        r_rd_first <= r_first_mem[w_rd_addr];
        r_rd_next  <= r_first_mem[w_rd_next_addr];
        r_rd_last  <= r_last_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end
            if (w_fin && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hip1 <= n_hip1;
        r_mid  <= n_mid;
        r_addr <= n_addr;
        if (w_fin && w_out_free) begin
            r_out_hit  <= w_fin_hit;
            r_out_slot <= w_fin_hit ? SLOT_W'(r_mid) : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.match_slot = r_out_slot;

endmodule

### rtl/core/ipr_checker.sv
// ipr_checker: port-level assertions for ip_range_table_lookup, bound to the top level
// depends on ipr_pkg
module ipr_checker import ipr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [ACT_W-1:0] i_in_action,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_hit,
    input t_slot            i_out_slot
);

    logic [1:0] r_pending, n_pending;
    logic       w_lookup_acc, w_rsp_acc;

    assign w_lookup_acc = i_in_valid && i_in_ready && (i_in_action == ACT_LOOKUP);
    assign w_rsp_acc    = i_out_valid && i_out_ready;

    // lookups taken but not yet answered
    always_comb begin
        n_pending = r_pending;
        if (w_lookup_acc && !w_rsp_acc) begin
            n_pending = r_pending + 2'd1;
        end else if (!w_lookup_acc && w_rsp_acc) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit)
                                        && $stable(i_out_slot))
        else $error("response word changed while stalled");

    a_rsp_has_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("response word without a pending lookup");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two lookups in flight");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd2 |-> !i_in_ready)
        else $error("request taken with search and output both busy");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_slot == '0)
        else $error("miss carries a nonzero slot");

endmodule

bind ip_range_table_lookup ipr_checker u_ipr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_action (i_req.action),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_hit   (o_rsp.hit),
    .i_out_slot  (o_rsp.match_slot)
);
